/* rtl/core/bnsr_pkg.sv */
// ----------------------------------------------------------------------------
// bnsr_pkg
// Shared constants, types and the sigmoid table for the batch-norm / SiLU /
// int8 requantization pipeline.
// ----------------------------------------------------------------------------
package bnsr_pkg;

  localparam int Channels = 64;
  localparam int ChAw     = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int SigDepth = 1024;
  localparam int SigAw    = $clog2(SigDepth);

  // sigmoid bin width in Q0.32, 8 / SigDepth
  localparam logic [63:0] SigStep = (64'd8 << 32) / 64'(SigDepth);

  // item function codes
  localparam logic FuncLoad   = 1'b0;
  localparam logic FuncSample = 1'b1;

  // configuration register indexes
  localparam int         CfgIdxW           = 2;
  localparam logic [1:0] CfgInputScale     = 2'd0;
  localparam logic [1:0] CfgWeightScale    = 2'd1;
  localparam logic [1:0] CfgOutReciprocal  = 2'd2;

  localparam logic [31:0] InputScaleRst    = 32'd16777216;
  localparam logic [31:0] WeightScaleRst   = 32'd16777216;
  localparam logic [31:0] OutReciprocalRst = 32'd65536;

  // magnitude limit of the Q.16 intermediates, 2^47-1
  localparam logic [46:0] BnLim   = '1;
  localparam logic [16:0] OneQ16  = 17'd65536;
  localparam logic [7:0]  YMagMax = 8'd128;
  localparam logic [7:0]  Int8Max = 8'd127;

  typedef struct packed {
    logic [5:0] ch;
    logic       last;
  } bnsr_tag_t;

  typedef logic [SigDepth-1:0][15:0] sig_tab_t;

  // truncating quotient by shift and subtract, only used to build constants
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-t) in Q0.32, 12-term series, each term truncated
  function automatic logic [63:0] exp_neg(input logic [63:0] t);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int k = 1; k <= 12; k++) begin
      term = div_u64((term * t) >> 32, 64'(k));
      if ((k & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // sigmoid over |x| in [0, 8), entry i sampled at bin center, Q0.16
  function automatic sig_tab_t build_sig_tab();
    sig_tab_t    tab;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] den;
    r = exp_neg(SigStep);
    e = exp_neg(SigStep >> 1);
    for (int i = 0; i < SigDepth; i++) begin
      den    = (64'd1 << 32) + e;
      tab[i] = 16'(div_u64((64'd1 << 48) + (den >> 1), den));
      e      = (e * r + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam sig_tab_t SigTab = build_sig_tab();

endpackage

/* rtl/core/bnsr_act.sv */
// ----------------------------------------------------------------------------
// bnsr_act
// SiLU and output requantization: sigmoid rom lookup, bn * sigmoid,
// multiply by the output reciprocal, round and saturate to int8.
// ----------------------------------------------------------------------------
module bnsr_act (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic signed [47:0] bn_i,
  input  bnsr_pkg::bnsr_tag_t tag_i,
  input  logic [31:0]        recip_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [7:0]  value_o,
  output logic [5:0]         out_channel_o,
  output logic               last_of_pixel_o
);

  localparam int IdxPW = 48 + bnsr_pkg::SigAw;

  logic en7, en8, en9, en10, en11, en12, en_out;
  logic v7_q, v8_q, v9_q, v10_q, v11_q, v12_q, out_vld_q;

  bnsr_pkg::bnsr_tag_t tag7_q, tag8_q, tag9_q, tag10_q, tag11_q, tag12_q;

  logic [46:0]               s7_bmag_q;
  logic                      s7_neg_q;
  logic [bnsr_pkg::SigAw-1:0] s7_idx_q;
  logic                      s7_ok_q;

  logic [46:0] s8_bmag_q;
  logic        s8_neg_q;
  logic [15:0] s8_psig_q;
  logic        s8_ok_q;

  logic [46:0] s9_bmag_q;
  logic        s9_neg_q;
  logic [16:0] s9_sig_q;

  logic [48:0] s10_pl_q;
  logic [31:0] s10_ph_q;
  logic        s10_neg_q;

  logic [46:0] s11_silu_q;
  logic        s11_neg_q;

  logic [63:0] s12_yl_q;
  logic [46:0] s12_yh_q;
  logic        s12_neg_q;

  logic signed [7:0] value_q;
  logic [5:0]        out_ch_q;
  logic              last_q;

  // combinational stage logic
  logic [47:0]      bn_abs;
  logic             bn_neg;
  logic [IdxPW-1:0] idx_prod;
  logic [16:0]      sig_pos;
  logic [16:0]      sig;
  logic [63:0]      silu_sum;
  logic [47:0]      silu_hi;
  logic [46:0]      silu;
  logic [79:0]      y_sum;
  logic [47:0]      y_hi;
  logic [7:0]       ymag;
  logic [7:0]       value_d;

  assign en_out  = !out_vld_q || !out_stall_i;
  assign en12    = !v12_q || en_out;
  assign en11    = !v11_q || en12;
  assign en10    = !v10_q || en11;
  assign en9     = !v9_q  || en10;
  assign en8     = !v8_q  || en9;
  assign en7     = !v7_q  || en8;
  assign ready_o = en7;

  always_comb begin
    bn_neg   = bn_i[47];
    bn_abs   = bn_neg ? (~bn_i + 48'd1) : bn_i;
    idx_prod = IdxPW'(bn_abs[46:0]) * IdxPW'(bnsr_pkg::SigDepth);
  end

  always_comb begin
    sig_pos = s8_ok_q ? {1'b0, s8_psig_q} : bnsr_pkg::OneQ16;
    sig     = s8_neg_q ? (bnsr_pkg::OneQ16 - sig_pos) : sig_pos;
  end

  always_comb begin
    silu_sum = {s10_ph_q, 32'd0} + 64'(s10_pl_q) + 64'h8000;
    silu_hi  = silu_sum[63:16];
    silu     = (silu_hi > 48'(bnsr_pkg::BnLim)) ? bnsr_pkg::BnLim : silu_hi[46:0];
  end

  always_comb begin
    y_sum = {s12_yh_q, 32'd0} + 80'(s12_yl_q) + 80'h8000_0000;
    y_hi  = y_sum[79:32];
    ymag  = (y_hi > 48'(bnsr_pkg::YMagMax)) ? bnsr_pkg::YMagMax : y_hi[7:0];
    if (s12_neg_q) begin
      value_d = ~ymag + 8'd1;
    end else if (ymag > bnsr_pkg::Int8Max) begin
      value_d = bnsr_pkg::Int8Max;
    end else begin
      value_d = ymag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q      <= 1'b0;
      v8_q      <= 1'b0;
      v9_q      <= 1'b0;
      v10_q     <= 1'b0;
      v11_q     <= 1'b0;
      v12_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (en7)    v7_q      <= valid_i;
      if (en8)    v8_q      <= v7_q;
      if (en9)    v9_q      <= v8_q;
      if (en10)   v10_q     <= v9_q;
      if (en11)   v11_q     <= v10_q;
      if (en12)   v12_q     <= v11_q;
      if (en_out) out_vld_q <= v12_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en7) begin
      s7_bmag_q <= bn_abs[46:0];
      s7_neg_q  <= bn_neg;
      s7_idx_q  <= idx_prod[19 +: bnsr_pkg::SigAw];
      s7_ok_q   <= (idx_prod >> 19) < IdxPW'(bnsr_pkg::SigDepth);
      tag7_q    <= tag_i;
    end
    if (en8) begin
      // registered rom read
      s8_psig_q <= bnsr_pkg::SigTab[s7_idx_q];
      s8_bmag_q <= s7_bmag_q;
      s8_neg_q  <= s7_neg_q;
      s8_ok_q   <= s7_ok_q;
      tag8_q    <= tag7_q;
    end
    if (en9) begin
      s9_sig_q  <= sig;
      s9_bmag_q <= s8_bmag_q;
      s9_neg_q  <= s8_neg_q;
      tag9_q    <= tag8_q;
    end
    if (en10) begin
      s10_pl_q  <= 49'(s9_bmag_q[31:0]) * 49'(s9_sig_q);
      s10_ph_q  <= 32'(s9_bmag_q[46:32]) * 32'(s9_sig_q);
      s10_neg_q <= s9_neg_q;
      tag10_q   <= tag9_q;
    end
    if (en11) begin
      s11_silu_q <= silu;
      s11_neg_q  <= s10_neg_q;
      tag11_q    <= tag10_q;
    end
    if (en12) begin
      s12_yl_q  <= 64'(s11_silu_q[31:0]) * 64'(recip_i);
      s12_yh_q  <= 47'(s11_silu_q[46:32]) * 47'(recip_i);
      s12_neg_q <= s11_neg_q;
      tag12_q   <= tag11_q;
    end
    if (en_out) begin
      value_q  <= value_d;
      out_ch_q <= tag12_q.ch;
      last_q   <= tag12_q.last;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign value_o         = value_q;
  assign out_channel_o   = out_ch_q;
  assign last_of_pixel_o = last_q;

endmodule

/* rtl/core/batchnorm_silu_requantize.sv */
// ----------------------------------------------------------------------------
// batchnorm_silu_requantize
// Dequantize, per-channel batch-norm, SiLU and int8 requantization of
// convolution accumulators; coefficients live in a one-port-read memory.
// Throughput: one item per cycle; each of the 13 stages holds only while
// the stage behind it is full and stalled, so bubbles are squeezed out.
// Reset clears all stage valids and returns the three config registers to
// their defaults; the coefficient memory is not cleared.
// ----------------------------------------------------------------------------
module batchnorm_silu_requantize (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic [5:0]                   channel_i,
  input  logic signed [31:0]           sample_i,
  input  logic signed [31:0]           coef_scale_i,
  input  logic signed [31:0]           coef_shift_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [7:0]            value_o,
  output logic [5:0]                   out_channel_o,
  output logic                         last_of_pixel_o,
  input  logic                         cfg_we_i,
  input  logic [bnsr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                  cfg_data_i
);

  logic [31:0] input_scale_q, weight_scale_q, out_recip_q;
  logic [63:0] k_q;

  logic en1, en2, en3, en4, en5, en6;
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, s6_vld_q;
  logic act_ready;
  logic in_acc, sample_acc, load_acc;
  logic ch_ok;
  logic [bnsr_pkg::ChAw-1:0] addr;

  logic [63:0] coef_mem [bnsr_pkg::Channels];
  logic [63:0] coef_rd_q;

  bnsr_pkg::bnsr_tag_t tag_in, tag1_q, tag2_q, tag3_q, tag4_q, tag5_q, tag6_q;

  logic [31:0] s1_smag_q;
  logic        s1_neg_q;
  logic        s1_ok_q;

  logic [63:0] s2_pxl_q, s2_pxh_q;
  logic        s2_neg_q;
  logic [31:0] s2_scale_q, s2_shift_q;

  logic [46:0] s3_xmag_q;
  logic [31:0] s3_scmag_q, s3_shift_q;
  logic        s3_sign_q;

  logic [63:0] s4_pbl_q;
  logic [46:0] s4_pbh_q;
  logic [31:0] s4_shift_q;
  logic        s4_sign_q;

  logic [46:0] s5_bmag_q;
  logic [31:0] s5_shift_q;
  logic        s5_sign_q;

  logic signed [47:0] s6_bn_q;

  logic [95:0]        x_sum;
  logic [63:0]        x_hi;
  logic [46:0]        xmag;
  logic               sc_neg;
  logic [31:0]        scmag;
  logic [78:0]        b_sum;
  logic [54:0]        b_hi;
  logic [46:0]        bmag;
  logic signed [48:0] bmag_s;
  logic signed [48:0] bn_add;
  logic signed [48:0] bn_lim_s;
  logic signed [48:0] bn_clamp;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      input_scale_q  <= bnsr_pkg::InputScaleRst;
      weight_scale_q <= bnsr_pkg::WeightScaleRst;
      out_recip_q    <= bnsr_pkg::OutReciprocalRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bnsr_pkg::CfgInputScale:    input_scale_q  <= cfg_data_i;
        bnsr_pkg::CfgWeightScale:   weight_scale_q <= cfg_data_i;
        bnsr_pkg::CfgOutReciprocal: out_recip_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // combined dequant scale, refreshed every cycle
  always_ff @(posedge clk_i) begin
    k_q <= 64'(input_scale_q) * 64'(weight_scale_q);
  end

  assign en6        = !s6_vld_q || act_ready;
  assign en5        = !s5_vld_q || en6;
  assign en4        = !s4_vld_q || en5;
  assign en3        = !s3_vld_q || en4;
  assign en2        = !s2_vld_q || en3;
  assign en1        = !s1_vld_q || en2;
  assign in_stall_o = !en1;

  assign in_acc     = in_valid_i && en1;
  assign sample_acc = in_acc && (func_i == bnsr_pkg::FuncSample);
  assign load_acc   = in_acc && (func_i == bnsr_pkg::FuncLoad);
  assign ch_ok      = 32'(channel_i) < 32'(bnsr_pkg::Channels);
  assign addr       = bnsr_pkg::ChAw'(channel_i);

  assign tag_in.ch   = channel_i;
  assign tag_in.last = ch_ok && (32'(channel_i) == 32'(bnsr_pkg::Channels - 1));

  // coefficient memory: {scale, shift}
  always_ff @(posedge clk_i) begin
    if (load_acc && ch_ok) begin
      coef_mem[addr] <= {coef_scale_i, coef_shift_i};
    end
    if (sample_acc) begin
      coef_rd_q <= coef_mem[addr];
    end
  end

  always_comb begin
    x_sum  = {s2_pxh_q, 32'd0} + 96'(s2_pxl_q) + 96'h8000_0000;
    x_hi   = x_sum[95:32];
    xmag   = (x_hi > 64'(bnsr_pkg::BnLim)) ? bnsr_pkg::BnLim : x_hi[46:0];
    sc_neg = s2_scale_q[31];
    scmag  = sc_neg ? (~s2_scale_q + 32'd1) : s2_scale_q;
  end

  always_comb begin
    b_sum = {s4_pbh_q, 32'd0} + 79'(s4_pbl_q) + (79'd1 << 23);
    b_hi  = b_sum[78:24];
    bmag  = (b_hi > 55'(bnsr_pkg::BnLim)) ? bnsr_pkg::BnLim : b_hi[46:0];
  end

  always_comb begin
    bmag_s   = $signed({2'b00, s5_bmag_q});
    bn_lim_s = $signed({2'b00, bnsr_pkg::BnLim});
    bn_add   = $signed({{17{s5_shift_q[31]}}, s5_shift_q})
             + (s5_sign_q ? -bmag_s : bmag_s);
    if (bn_add > bn_lim_s) begin
      bn_clamp = bn_lim_s;
    end else if (bn_add < -bn_lim_s) begin
      bn_clamp = -bn_lim_s;
    end else begin
      bn_clamp = bn_add;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else begin
      if (en1) s1_vld_q <= sample_acc;
      if (en2) s2_vld_q <= s1_vld_q;
      if (en3) s3_vld_q <= s2_vld_q;
      if (en4) s4_vld_q <= s3_vld_q;
      if (en5) s5_vld_q <= s4_vld_q;
      if (en6) s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_smag_q <= sample_i[31] ? (~sample_i + 32'd1) : sample_i;
      s1_neg_q  <= sample_i[31];
      s1_ok_q   <= ch_ok;
      tag1_q    <= tag_in;
    end
    if (en2) begin
      s2_pxl_q   <= 64'(s1_smag_q) * 64'(k_q[31:0]);
      s2_pxh_q   <= 64'(s1_smag_q) * 64'(k_q[63:32]);
      s2_neg_q   <= s1_neg_q;
      // channels past the table use zero coefficients
      s2_scale_q <= s1_ok_q ? coef_rd_q[63:32] : 32'd0;
      s2_shift_q <= s1_ok_q ? coef_rd_q[31:0] : 32'd0;
      tag2_q     <= tag1_q;
    end
    if (en3) begin
      s3_xmag_q  <= xmag;
      s3_scmag_q <= scmag;
      s3_sign_q  <= s2_neg_q ^ sc_neg;
      s3_shift_q <= s2_shift_q;
      tag3_q     <= tag2_q;
    end
    if (en4) begin
      s4_pbl_q   <= 64'(s3_xmag_q[31:0]) * 64'(s3_scmag_q);
      s4_pbh_q   <= 47'(s3_xmag_q[46:32]) * 47'(s3_scmag_q);
      s4_sign_q  <= s3_sign_q;
      s4_shift_q <= s3_shift_q;
      tag4_q     <= tag3_q;
    end
    if (en5) begin
      s5_bmag_q  <= bmag;
      s5_sign_q  <= s4_sign_q;
      s5_shift_q <= s4_shift_q;
      tag5_q     <= tag4_q;
    end
    if (en6) begin
      s6_bn_q <= bn_clamp[47:0];
      tag6_q  <= tag5_q;
    end
  end

  bnsr_act u_act (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (s6_vld_q),
    .ready_o         (act_ready),
    .bn_i            (s6_bn_q),
    .tag_i           (tag6_q),
    .recip_i         (out_recip_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .value_o         (value_o),
    .out_channel_o   (out_channel_o),
    .last_of_pixel_o (last_of_pixel_o)
  );

  a_sample_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && func_i == bnsr_pkg::FuncSample) |=> s1_vld_q)
    else $error("accepted sample beat did not enter the pipeline");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && func_i == bnsr_pkg::FuncLoad) |=> !s1_vld_q)
    else $error("coefficient load beat entered the sample pipeline");

  a_handoff_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s6_vld_q && !act_ready) |=> (s6_vld_q && $stable(s6_bn_q)))
    else $error("bn stage lost or changed while back-pressured");

  a_last_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_pixel_o)
      |-> (32'(out_channel_o) == 32'(bnsr_pkg::Channels - 1)))
    else $error("last_of_pixel set on a channel other than the last");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for batchnorm_silu_requantize. Loads per-channel
// batch-norm coefficients, streams accumulator samples under several scale
// settings and handshake idle mixes, and compares every int8 result beat
// field by field against an in-bench fixed-point model of the datapath or a typed-in value.
// ----------------------------------------------------------------------------
module testbench;

  localparam int         DrainCycles = 24;
  localparam int         PhaseBeats  = 208;
  localparam int         HoldCycles  = 80;
  localparam int         MaxReports  = 10;
  localparam logic [1:0] CfgSpare    = 2'd3;  // unmapped index, writes must be dropped

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  typedef struct packed {
    logic               func;
    logic [5:0]         ch;
    logic signed [31:0] sample;
    logic signed [31:0] cscale;
    logic signed [31:0] cshift;
  } beat_t;

  typedef struct packed {
    logic signed [7:0] value;
    logic [5:0]        ch;
    logic              last;
  } int8_res_t;

  typedef struct packed {
    beat_t             b;
    logic              known;
    logic signed [7:0] value;
  } dir_row_t;

  // expected value typed in only where the result is obvious (zero in, saturated ends)
  localparam dir_row_t DirRows [20] = '{
    '{'{bnsr_pkg::FuncLoad,   6'd0,  32'h0,         32'h0100_0000, 32'h0        }, 1'b0, 8'sd0},
    '{'{bnsr_pkg::FuncLoad,   6'd63, 32'h0,         32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, 8'sd0},
    '{'{bnsr_pkg::FuncLoad,   6'd1,  32'h0,         32'h8000_0000, 32'h8000_0000}, 1'b0, 8'sd0},
    '{'{bnsr_pkg::FuncLoad,   6'd2,  32'h0,         32'h0,         32'h0        }, 1'b0, 8'sd0},
    '{'{bnsr_pkg::FuncLoad,   6'd3,  32'h0,         32'h00C0_0000, 32'hFFFF_0000}, 1'b0, 8'sd0},
    '{'{bnsr_pkg::FuncSample, 6'd0,  32'h0,         32'h5A5A_5A5A, 32'hA5A5_A5A5}, 1'b1, 8'sd0},
    '{'{bnsr_pkg::FuncSample, 6'd0,  32'h1,         32'h0,         32'h0        }, 1'b0, 8'sd0},
    '{'{bnsr_pkg::FuncSample, 6'd0,  32'h7FFF_FFFF, 32'h0,         32'h0        }, 1'b1, 8'sd127},
    '{'{bnsr_pkg::FuncSample, 6'd0,  32'h8000_0000, 32'h0,         32'h0        }, 1'b1, 8'sd0},
    '{'{bnsr_pkg::FuncSample, 6'd63, 32'h0,         32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, 8'sd127},
    '{'{bnsr_pkg::FuncSample, 6'd63, 32'h7FFF_FFFF, 32'h0,         32'h0        }, 1'b1, 8'sd127},
    '{'{bnsr_pkg::FuncSample, 6'd63, 32'h8000_0000, 32'h0,         32'h0        }, 1'b1, 8'sd0},
    '{'{bnsr_pkg::FuncSample, 6'd1,  32'h7FFF_FFFF, 32'h0,         32'h0        }, 1'b1, 8'sd0},
    '{'{bnsr_pkg::FuncSample, 6'd1,  32'h8000_0000, 32'h0,         32'h0        }, 1'b1, 8'sd127},
    '{'{bnsr_pkg::FuncSample, 6'd2,  32'd12345,     32'h0,         32'h0        }, 1'b1, 8'sd0},
    '{'{bnsr_pkg::FuncSample, 6'd3,  32'hFFFF_FC18, 32'h0,         32'h0        }, 1'b0, 8'sd0},
    '{'{bnsr_pkg::FuncSample, 6'd3,  32'd70000,     32'h0,         32'h0        }, 1'b0, 8'sd0},
    '{'{bnsr_pkg::FuncLoad,   6'd0,  32'h0,         32'h0180_0000, 32'h0000_8000}, 1'b0, 8'sd0},
    '{'{bnsr_pkg::FuncSample, 6'd0,  32'hFFFF_FFFD, 32'h0,         32'h0        }, 1'b0, 8'sd0},
    '{'{bnsr_pkg::FuncSample, 6'd0,  32'd5,         32'h0,         32'h0        }, 1'b0, 8'sd0}
  };

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         in_valid_i      = 1'b0;
  logic                         in_stall_o;
  logic                         func_i          = bnsr_pkg::FuncLoad;
  logic [5:0]                   channel_i       = '0;
  logic signed [31:0]           sample_i        = '0;
  logic signed [31:0]           coef_scale_i    = '0;
  logic signed [31:0]           coef_shift_i    = '0;
  logic                         out_valid_o;
  logic                         out_stall_i     = 1'b0;
  logic signed [7:0]            value_o;
  logic [5:0]                   out_channel_o;
  logic                         last_of_pixel_o;
  logic                         cfg_we_i        = 1'b0;
  logic [bnsr_pkg::CfgIdxW-1:0] cfg_idx_i       = '0;
  logic [31:0]                  cfg_data_i      = '0;

  // model state
  logic [31:0]         in_scale_q      = bnsr_pkg::InputScaleRst;
  logic [31:0]         wt_scale_q      = bnsr_pkg::WeightScaleRst;
  logic [31:0]         out_recip_q     = bnsr_pkg::OutReciprocalRst;
  logic signed [31:0]  bn_scale_tab [bnsr_pkg::Channels];
  logic signed [31:0]  bn_shift_tab [bnsr_pkg::Channels];
  logic [15:0]         logistic_q16 [bnsr_pkg::SigDepth];

  int8_res_t           pending_int8 [$];
  idle_mode_e          idle_mode    = IdleNone;
  int                  hold_left    = 0;
  int                  fail_count   = 0;
  int                  beats_in     = 0;
  int                  results_seen = 0;
  int                  settings     = 0;

  batchnorm_silu_requantize uut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  // (a*b + half) >> sh on the exact product, capped at lim
  function automatic logic [63:0] mul_round_sat(input logic [63:0] a, input logic [63:0] b,
                                                input int sh, input logic [63:0] lim);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b} + (128'd1 << (sh - 1))) >> sh;
    return (p > {64'd0, lim}) ? lim : p[63:0];
  endfunction

  // exp(-t) in Q0.32, 12-term series with truncated terms
  function automatic logic [63:0] decay_q32(input logic [63:0] t);
    logic [63:0] acc;
    logic [63:0] term;
    acc  = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * t) >> 32) / 64'(k);
      acc  = (k % 2 == 1) ? acc - term : acc + term;
    end
    return acc;
  endfunction

  function automatic void fill_logistic();
    logic [63:0] step;
    logic [63:0] ratio;
    logic [63:0] e;
    logic [63:0] den;
    step  = (64'd8 << 32) / 64'(bnsr_pkg::SigDepth);
    ratio = decay_q32(step);
    e     = decay_q32(step >> 1);
    for (int i = 0; i < bnsr_pkg::SigDepth; i++) begin
      den             = (64'd1 << 32) + e;
      logistic_q16[i] = 16'(((64'd1 << 48) + (den >> 1)) / den);
      e               = (e * ratio + (64'd1 << 31)) >> 32;
    end
  endfunction

  // applies one accepted beat; returns 1 with the int8 result for a sample
  function automatic logic bn_silu_int8(input beat_t b, output int8_res_t r);
    logic [63:0]        lim;
    logic [63:0]        smag;
    logic [63:0]        xmag;
    logic [63:0]        scmag;
    logic [63:0]        bmag;
    logic [63:0]        idx;
    logic [63:0]        psig;
    logic [63:0]        sig;
    logic [63:0]        silu;
    logic [63:0]        ymag;
    logic signed [63:0] s;
    logic signed [63:0] sc;
    logic signed [63:0] bn;
    logic signed [63:0] y;
    logic               bneg;
    r   = '0;
    lim = 64'(bnsr_pkg::BnLim);
    if (b.func == bnsr_pkg::FuncLoad) begin
      bn_scale_tab[b.ch] = b.cscale;
      bn_shift_tab[b.ch] = b.cshift;
      return 1'b0;
    end
    s     = b.sample;
    smag  = (s < 0) ? -s : s;
    xmag  = mul_round_sat(smag, {32'd0, in_scale_q} * {32'd0, wt_scale_q}, 32, lim);
    sc    = bn_scale_tab[b.ch];
    bn    = bn_shift_tab[b.ch];
    scmag = (sc < 0) ? -sc : sc;
    bmag  = mul_round_sat(xmag, scmag, 24, lim);
    if ((s < 0) != (sc < 0)) begin
      bn = bn - $signed(bmag);
    end else begin
      bn = bn + $signed(bmag);
    end
    if (bn > $signed(lim)) bn = $signed(lim);
    if (bn < -$signed(lim)) bn = -$signed(lim);
    bneg = bn < 0;
    bmag = bneg ? -bn : bn;
    // table spans |x| < 8.0, past it the sigmoid is taken as one
    idx  = (bmag * 64'(bnsr_pkg::SigDepth)) >> 19;
    psig = (idx < 64'(bnsr_pkg::SigDepth)) ? 64'(logistic_q16[idx[bnsr_pkg::SigAw-1:0]])
                                           : 64'(bnsr_pkg::OneQ16);
    sig  = bneg ? 64'(bnsr_pkg::OneQ16) - psig : psig;
    silu = mul_round_sat(bmag, sig, 16, lim);
    ymag = mul_round_sat(silu, {32'd0, out_recip_q}, 32, 64'd128);
    y    = bneg ? -$signed(ymag) : $signed(ymag);
    if (y > 127) y = 127;
    if (y < -128) y = -128;
    r.value = y[7:0];
    r.ch    = b.ch;
    r.last  = (b.ch == 6'(bnsr_pkg::Channels - 1));
    return 1'b1;
  endfunction

  function automatic logic signed [31:0] span_rand(input int lo);
    logic signed [31:0] v;
    v = $urandom;
    return v >>> $urandom_range(lo, 31);
  endfunction

  task automatic send_beat(input beat_t b, input logic known, input logic signed [7:0] kval);
    int8_res_t r;
    logic      has;
    while ($urandom_range(0, 99) <
           ((idle_mode == IdleSender) ? 47 : (idle_mode == IdleBoth) ? 15 : 0)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= b.func;
    channel_i    <= b.ch;
    sample_i     <= b.sample;
    coef_scale_i <= b.cscale;
    coef_shift_i <= b.cshift;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_in++;
    has = bn_silu_int8(b, r);
    if (has) begin
      if (known) r.value = kval;
      pending_int8.push_back(r);
    end
  endtask

  task automatic drain();
    while (pending_int8.size() != 0) @(posedge clk_i);
    // loads leave no result behind, so give the pipe its full depth
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [bnsr_pkg::CfgIdxW-1:0] idx, input logic [31:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    case (idx)
      bnsr_pkg::CfgInputScale: begin
        in_scale_q = d;
      end
      bnsr_pkg::CfgWeightScale: begin
        wt_scale_q = d;
      end
      bnsr_pkg::CfgOutReciprocal: begin
        out_recip_q = d;
      end
      default: begin
      end
    endcase
  endtask

  task automatic run_phase(input logic [31:0] in_scale, input logic [31:0] wt_scale,
                           input logic [31:0] recip, input idle_mode_e mode, input bit hold);
    beat_t b;
    drain();
    write_reg(bnsr_pkg::CfgInputScale, in_scale);
    write_reg(bnsr_pkg::CfgWeightScale, wt_scale);
    write_reg(bnsr_pkg::CfgOutReciprocal, recip);
    write_reg(CfgSpare, $urandom);
    cfg_we_i  <= 1'b0;
    idle_mode = mode;
    settings++;
    if (hold) hold_left = HoldCycles;
    for (int n = 0; n < PhaseBeats; n++) begin
      b.ch     = ($urandom_range(0, 9) == 0) ? 6'(bnsr_pkg::Channels - 1) : 6'($urandom);
      b.sample = span_rand(0);
      b.cscale = ($urandom_range(0, 9) < 7) ? span_rand(4) : span_rand(31);
      b.cshift = span_rand(0);
      // mostly samples on loaded channels, with coefficient reloads mixed in
      b.func   = ($urandom_range(0, 99) < 10) ? bnsr_pkg::FuncLoad : bnsr_pkg::FuncSample;
      send_beat(b, 1'b0, 8'sd0);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin : result_side
    int8_res_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_int8.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("unexpected result beat: value %0d ch %0d last %0b",
                     value_o, out_channel_o, last_of_pixel_o);
          end
        end else begin
          want = pending_int8.pop_front();
          if (value_o !== want.value || out_channel_o !== want.ch ||
              last_of_pixel_o !== want.last) begin
            fail_count++;
            if (fail_count <= MaxReports) begin
              $display("result mismatch: exp value %0d ch %0d last %0b, got %0d ch %0d last %0b",
                       want.value, want.ch, want.last,
                       value_o, out_channel_o, last_of_pixel_o);
            end
          end
        end
      end
      out_stall_i <= (hold_left > 0) || ($urandom_range(0, 99) <
                     ((idle_mode == IdleReceiver) ? 47 : (idle_mode == IdleBoth) ? 15 : 0));
      if (hold_left > 0) hold_left--;
    end
  end

  initial begin : stimulus
    beat_t b;
    fill_logistic();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < $size(DirRows); i++) begin
      send_beat(DirRows[i].b, DirRows[i].known, DirRows[i].value);
    end

    // fill the whole coefficient table before random samples start
    for (int c = 0; c < bnsr_pkg::Channels; c++) begin
      b.func   = bnsr_pkg::FuncLoad;
      b.ch     = 6'(c);
      b.sample = span_rand(0);
      b.cscale = span_rand(4);
      b.cshift = span_rand(0);
      send_beat(b, 1'b0, 8'sd0);
    end
    in_valid_i <= 1'b0;

    run_phase(bnsr_pkg::InputScaleRst, bnsr_pkg::WeightScaleRst, bnsr_pkg::OutReciprocalRst,
              IdleNone, 1'b1);
    run_phase(32'h0010_0000, 32'h0040_0000, 32'h0010_0000, IdleSender, 1'b0);
    run_phase(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, IdleReceiver, 1'b0);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, IdleBoth, 1'b0);
    run_phase($urandom, $urandom, $urandom, IdleNone, 1'b0);
    run_phase($urandom_range(1 << 20, 1 << 26), $urandom_range(1 << 20, 1 << 26),
              $urandom_range(1 << 12, 1 << 22), IdleSender, 1'b0);
    run_phase(32'h1, 32'h0100_0000, 32'h7FFF_FFFF, IdleReceiver, 1'b0);
    run_phase($urandom_range(1 << 22, 1 << 25), $urandom_range(1 << 22, 1 << 25),
              $urandom_range(1 << 14, 1 << 20), IdleBoth, 1'b1);
    drain();

    $display("covered %0d input beats (%0d directed), %0d result beats, %0d register settings",
             beats_in, $size(DirRows), results_seen, settings);
    $display("incl. zero and full-scale registers, all idle mixes, %0d-cycle output hold",
             HoldCycles);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* batchnorm_silu_requantize.f */
rtl/core/bnsr_pkg.sv
rtl/core/bnsr_act.sv
rtl/core/batchnorm_silu_requantize.sv
tb/testbench.sv
